@@ rtl/core/rmt_pkg.sv @@
// Shared types and sizing constants for the running median tracker.
// Used by the cell chain, the median select tree, the top level and the checker.
package rmt_pkg;

    // Store depth and the widths that follow from it.
    localparam int MaxSamples = 1024;
    localparam int SampleW    = 16;
    localparam int IdxW       = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
    localparam int CntW       = $clog2(MaxSamples + 1);

    // The median select tree: groups of cells reduced first, then the groups.
    localparam int GrpSize    = 2 ** ((IdxW + 1) / 2);
    localparam int NumGrp     = (MaxSamples + GrpSize - 1) / GrpSize;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [IdxW-1:0]           t_idx;
    typedef logic [CntW-1:0]           t_cnt;

    // What one cell hands to its upper neighbor: its value and whether it shifts up.
    typedef struct packed {
        logic    gt;
        t_sample val;
    } t_link;

    // Item sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_REDUCE
    } t_state;

endpackage

@@ rtl/core/rmt_cell.sv @@
// One cell of the sorted sample chain: holds one stored sample in ascending order.
// Depends on rmt_pkg for the sample, index, count and link types.
module rmt_cell (
    input  logic            i_clk,
    input  logic            i_ins,
    input  rmt_pkg::t_idx   i_idx,
    input  rmt_pkg::t_cnt   i_count,
    input  rmt_pkg::t_sample i_sample,
    input  rmt_pkg::t_idx   i_med_idx,
    input  rmt_pkg::t_link  i_prev,
    output rmt_pkg::t_link  o_link,
    output rmt_pkg::t_sample o_pick
);
    import rmt_pkg::*;

    t_sample r_val;
    t_sample n_val;
    logic    w_occ;
    logic    w_at_end;
    logic    w_gt;

    // Position of this cell relative to the fill level of the store.
    assign w_occ    = t_cnt'(i_idx) < i_count;
    assign w_at_end = t_cnt'(i_idx) == i_count;

    // A stored sample greater than the new one moves up by one cell.
    assign w_gt = w_occ && (r_val > i_sample);

    // Take the lower neighbor's value if it moves up, else the new sample at the
    // insertion point, else keep what is stored.
    always_comb begin
        if (i_prev.gt) begin
            n_val = i_prev.val;
        end else if (w_gt || w_at_end) begin
            n_val = i_sample;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            r_val <= n_val;
        end
    end

    assign o_link = '{gt: w_gt, val: r_val};

    // Only the cell at the median position drives its value into the select tree.
    assign o_pick = (i_idx == i_med_idx) ? r_val : '0;

endmodule

@@ rtl/core/rmt_med_tree.sv @@
// Two-level registered OR tree that collects the median cell's value.
// Depends on rmt_pkg for the group sizing and the sample type.
module rmt_med_tree (
    input  logic             i_clk,
    input  logic             i_load_out,
    input  rmt_pkg::t_sample i_picks [rmt_pkg::MaxSamples],
    output rmt_pkg::t_sample o_median
);
    import rmt_pkg::*;

    t_sample r_grp [NumGrp];
    t_sample n_grp [NumGrp];
    t_sample r_median;
    t_sample n_median;

    // First level: each group ORs its cells; at most one cell is nonzero overall.
    always_comb begin
        for (int g = 0; g < NumGrp; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GrpSize; k++) begin
                if (g * GrpSize + k < MaxSamples) begin
                    n_grp[g] = n_grp[g] | i_picks[g * GrpSize + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    // Second level: OR the group results into the output word.
    always_comb begin
        n_median = '0;
        for (int g = 0; g < NumGrp; g++) begin
            n_median = n_median | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_median <= n_median;
        end
    end

    assign o_median = r_median;

endmodule

@@ rtl/core/running_median_tracker.sv @@
// Top level of the running median tracker: cell chain, count, sequencer, output.
// Depends on rmt_pkg, rmt_cell and rmt_med_tree.
//
// Each accepted word carries a signed 16-bit sample and a start flag; the block
// returns one word with the lower median of all samples since the last start,
// and a dropped flag when the store of MaxSamples samples was full and the
// sample was ignored. Samples live in a chain of cells kept in ascending order;
// a new sample is inserted at the accepting edge by every greater cell shifting
// up one place to its neighbor. The median cell's value then passes through a
// two-level registered select tree whose second level loads the output
// register. The input stays stalled from the accepting edge until the result
// word has loaded the output register; only then is a new word taken.
// The output register parts the two channels: the input stays open while a
// result waits, and only a following result that is ready to load waits in the
// tree until the receiver takes the previous one. No clearing pass is needed
// after reset.
module running_median_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rmt_pkg::t_sample i_sample,
    input  logic             i_start_req,
    output logic             o_valid,
    input  logic             i_stall,
    output rmt_pkg::t_sample o_median,
    output logic             o_dropped
);
    import rmt_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_cnt    r_count;
    t_idx    r_med_idx;
    logic    r_dropped;
    logic    r_out_valid;
    logic    r_out_dropped;
    logic    w_acc;
    logic    w_full;
    logic    w_ins;
    logic    w_load_out;
    logic    w_out_free;
    t_cnt    w_cnt_eff;
    t_link   w_head;
    t_link   w_link  [MaxSamples];
    t_sample w_picks [MaxSamples];

    // Input handshake and the fill level this word sees after an optional start.
    assign w_acc     = i_valid && !o_stall;
    assign w_cnt_eff = i_start_req ? '0 : r_count;
    assign w_full    = w_cnt_eff == t_cnt'(MaxSamples);
    assign w_ins     = w_acc && !w_full;

    // Fill count, median position and the dropped flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_med_idx <= '0;
            r_dropped <= 1'b0;
        end else if (w_acc) begin
            r_dropped <= w_full;
            if (!w_full) begin
                r_count   <= w_cnt_eff + t_cnt'(1);
                r_med_idx <= t_idx'(w_cnt_eff >> 1);
            end
        end
    end

    // The bottom cell never receives a shifted value.
    assign w_head = '{gt: 1'b0, val: i_sample};

    // Sorted chain of cells.
    for (genvar gi = 0; gi < MaxSamples; gi++) begin : g_cell
        rmt_cell u_cell (
            .i_clk     (i_clk),
            .i_ins     (w_ins),
            .i_idx     (t_idx'(gi)),
            .i_count   (w_cnt_eff),
            .i_sample  (i_sample),
            .i_med_idx (r_med_idx),
            .i_prev    ((gi == 0) ? w_head : w_link[(gi == 0) ? 0 : gi - 1]),
            .o_link    (w_link[gi]),
            .o_pick    (w_picks[gi])
        );
    end

    rmt_med_tree u_med_tree (
        .i_clk      (i_clk),
        .i_load_out (w_load_out),
        .i_picks    (w_picks),
        .o_median   (o_median)
    );

    // The output register can take a new word when it is empty or being read.
    assign w_out_free = !r_out_valid || !i_stall;

    // Output word valid flag and dropped flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_out_dropped <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid   <= 1'b1;
            r_out_dropped <= r_dropped;
        end else if (!i_stall) begin
            r_out_valid   <= 1'b0;
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_GATHER;
                end
            end
            ST_GATHER: n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_stall    = 1'b1;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE:   o_stall    = 1'b0;
            ST_GATHER: w_load_out = 1'b0;
            ST_REDUCE: w_load_out = w_out_free;
            default:   o_stall    = 1'b1;
        endcase
    end

    assign o_valid   = r_out_valid;
    assign o_dropped = r_out_dropped;

endmodule

@@ rtl/core/rmt_checker.sv @@
// Port-level checks for the running median tracker, and their attachment.
// Depends on rmt_pkg and binds to running_median_tracker.
module rmt_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input rmt_pkg::t_sample o_median,
    input logic             o_dropped
);
    import rmt_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_median) && $stable(o_dropped))
        else $error("result word changed while stalled");

    // An accepted word keeps the input busy while it passes through both select tree levels.
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("block not busy after accepting a word");

    // With no result waiting, an accepted word's result is shown once it has passed through the select tree.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> ##2 o_valid)
        else $error("result not shown two cycles after acceptance");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind running_median_tracker rmt_checker u_rmt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_median  (o_median),
    .o_dropped (o_dropped)
);
